>>> rtl/ip_range_lookup_macros.svh
// Assertion macros shared by the IP range lookup RTL.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef IP_RANGE_LOOKUP_MACROS_SVH
`define IP_RANGE_LOOKUP_MACROS_SVH

// Same-cycle implication, switched off while reset is held.
`define IRL_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("irl assertion failed");

// Next-cycle implication, switched off while reset is held.
`define IRL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("irl assertion failed");

`endif

>>> rtl/irl_pkg.sv
// Package for the IP range lookup: widths, codes, record and handshake types.
// No dependencies; used by every module of the block.
package irl_pkg;

    localparam int RECORDS = 1024;
    localparam int IDX_W   = $clog2(RECORDS);
    localparam int CNT_W   = $clog2(RECORDS + 1);
    localparam int SLOT_W  = 10;
    localparam int ADDR_W  = 32;
    localparam int CFG_W   = 11;

    localparam logic FUNC_WRITE  = 1'b0;
    localparam logic FUNC_LOOKUP = 1'b1;

    localparam logic STATUS_FOUND = 1'b0;
    localparam logic STATUS_MISS  = 1'b1;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_SEARCH
    } state_t;

    typedef struct packed {
        logic [ADDR_W-1:0] first;
        logic [ADDR_W-1:0] last;
        logic [ADDR_W-1:0] offset;
    } record_t;

    typedef struct packed {
        logic write;
        logic start;
        logic step;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic active;
        logic hit;
        logic out_free;
    } status_t;

endpackage

>>> rtl/ip_range_lookup.sv
// IP range lookup: a sorted table of address ranges with binary search lookup.
// Depends on irl_pkg, irl_ctrl and irl_datapath.
//
// Usage: the input channel (in_valid / in_stall) carries one word per item.
// func selects a write, which stores address, range_last and payload_offset
// as the record at slot, or a lookup, which searches the first record_count
// records for a range holding address. Only lookups give a result word on
// the output channel (out_valid / out_stall).
// A write is stored when it is taken, and the next word is taken in the following cycle.
// A lookup is taken in idle, then probes the single-port record memory until
// it hits or the bounds meet, and a miss is reported once they have met.
// The result is registered and out_valid rises the cycle after the search
// ends, or later while an earlier result still waits under out_stall. While
// a result waits under out_stall the block still takes writes and one further
// lookup, which holds its result until the output is free.
// The record_count register is written through cfg_valid / cfg_ready, and
// cfg_ready is always high; write it only while no lookup is pending.
// Reset clears record_count, so every lookup misses until it is written.
// Record contents are not cleared by reset and must be written before use.
module ip_range_lookup (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic                       func,
    input  logic [irl_pkg::SLOT_W-1:0] slot,
    input  logic [irl_pkg::ADDR_W-1:0] address,
    input  logic [irl_pkg::ADDR_W-1:0] range_last,
    input  logic [irl_pkg::ADDR_W-1:0] payload_offset,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic                       status,
    output logic [irl_pkg::ADDR_W-1:0] hit_begin,
    output logic [irl_pkg::ADDR_W-1:0] hit_end,
    output logic [irl_pkg::SLOT_W-1:0] hit_index,
    output logic [irl_pkg::ADDR_W-1:0] hit_offset,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [irl_pkg::CFG_W-1:0]  cfg_data
);
    import irl_pkg::*;

    cmd_t    cmd;
    status_t stat;

    assign cfg_ready = 1'b1;

    irl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .func     (func),
        .in_stall (in_stall),
        .cmd      (cmd),
        .stat     (stat)
    );

    irl_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .slot           (slot),
        .address        (address),
        .range_last     (range_last),
        .payload_offset (payload_offset),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .hit_begin      (hit_begin),
        .hit_end        (hit_end),
        .hit_index      (hit_index),
        .hit_offset     (hit_offset)
    );

endmodule

>>> rtl/irl_ctrl.sv
// Controller for the IP range lookup: sequences writes and binary search probes.
// Depends on irl_pkg and ip_range_lookup_macros.svh.
`include "ip_range_lookup_macros.svh"

module irl_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             func,
    output logic             in_stall,
    output irl_pkg::cmd_t    cmd,
    input  irl_pkg::status_t stat
);
    import irl_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    if (func == FUNC_WRITE)
                    begin
                        cmd.write = 1'b1;
                    end
                    else
                    begin
                        cmd.start  = 1'b1;
                        state_next = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH:
            begin
                // The search ends on a hit or once the bounds have met; the result
                // waits here until the output register can take it.
                if (!stat.active || stat.hit)
                begin
                    if (stat.out_free)
                    begin
                        cmd.finish = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    cmd.step = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `IRL_ASSERT_NEXT(a_finish_to_idle, cmd.finish, state_reg == ST_IDLE)

endmodule

>>> rtl/irl_datapath.sv
// Datapath for the IP range lookup: record memory, search bounds and result register.
// Depends on irl_pkg and ip_range_lookup_macros.svh.
`include "ip_range_lookup_macros.svh"

module irl_datapath (
    input  logic                       clk,
    input  logic                       rst_n,
    input  irl_pkg::cmd_t              cmd,
    output irl_pkg::status_t           stat,
    input  logic [irl_pkg::SLOT_W-1:0] slot,
    input  logic [irl_pkg::ADDR_W-1:0] address,
    input  logic [irl_pkg::ADDR_W-1:0] range_last,
    input  logic [irl_pkg::ADDR_W-1:0] payload_offset,
    input  logic                       cfg_valid,
    input  logic                       cfg_ready,
    input  logic [irl_pkg::CFG_W-1:0]  cfg_data,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic                       status,
    output logic [irl_pkg::ADDR_W-1:0] hit_begin,
    output logic [irl_pkg::ADDR_W-1:0] hit_end,
    output logic [irl_pkg::SLOT_W-1:0] hit_index,
    output logic [irl_pkg::ADDR_W-1:0] hit_offset
);
    import irl_pkg::*;

    record_t           mem [RECORDS];
    record_t           rd_reg;
    logic [CFG_W-1:0]  count_reg;
    logic [CNT_W-1:0]  low_reg;
    logic [CNT_W-1:0]  high_reg;
    logic [CNT_W-1:0]  mid_reg;
    logic [ADDR_W-1:0] key_reg;
    logic              out_valid_reg;
    logic              status_reg;
    logic [ADDR_W-1:0] begin_reg;
    logic [ADDR_W-1:0] end_reg;
    logic [SLOT_W-1:0] index_reg;
    logic [ADDR_W-1:0] offset_reg;

    logic [CNT_W-1:0]  count_clamped;
    logic              probe_le;
    logic [CNT_W-1:0]  low_next;
    logic [CNT_W-1:0]  high_next;
    logic [CNT_W:0]    mid_sum;
    logic [CNT_W-1:0]  mid_next;
    logic              rd_en;
    logic              slot_ok;

    always_comb
    begin
        if (CNT_W'(count_reg) > CNT_W'(RECORDS))
        begin
            count_clamped = CNT_W'(RECORDS);
        end
        else
        begin
            count_clamped = CNT_W'(count_reg);
        end
    end

    // One probe a cycle: the compare on the word just read picks the new bounds,
    // and the midpoint of those bounds is read in the same cycle.
    assign probe_le = rd_reg.first <= key_reg;

    always_comb
    begin
        if (cmd.start)
        begin
            low_next  = '0;
            high_next = count_clamped;
        end
        else if (probe_le)
        begin
            low_next  = mid_reg + CNT_W'(1);
            high_next = high_reg;
        end
        else
        begin
            low_next  = low_reg;
            high_next = mid_reg;
        end
    end

    assign mid_sum  = {1'b0, low_next} + {1'b0, high_next};
    assign mid_next = mid_sum[CNT_W:1];
    assign rd_en    = cmd.start || cmd.step;
    assign slot_ok  = CNT_W'(slot) < CNT_W'(RECORDS);

    assign stat.active   = low_reg < high_reg;
    assign stat.hit      = probe_le && (rd_reg.last >= key_reg);
    assign stat.out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk)
    begin
        if (cmd.write && slot_ok)
        begin
            mem[IDX_W'(slot)] <= '{first: address, last: range_last, offset: payload_offset};
        end
        if (rd_en)
        begin
            rd_reg <= mem[mid_next[IDX_W-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            low_reg   <= '0;
            high_reg  <= '0;
            mid_reg   <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                count_reg <= cfg_data;
            end
            if (rd_en)
            begin
                low_reg  <= low_next;
                high_reg <= high_next;
                mid_reg  <= mid_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            key_reg <= address;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            if (stat.active && stat.hit)
            begin
                status_reg <= STATUS_FOUND;
                begin_reg  <= rd_reg.first;
                end_reg    <= rd_reg.last;
                index_reg  <= SLOT_W'(mid_reg);
                offset_reg <= rd_reg.offset;
            end
            else
            begin
                status_reg <= STATUS_MISS;
                begin_reg  <= '0;
                end_reg    <= '0;
                index_reg  <= '0;
                offset_reg <= '0;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign hit_begin  = begin_reg;
    assign hit_end    = end_reg;
    assign hit_index  = index_reg;
    assign hit_offset = offset_reg;

    `IRL_ASSERT_NOW(a_bounds_ordered, 1'b1, low_reg <= high_reg)
    `IRL_ASSERT_NOW(a_mid_in_bounds, stat.active, (mid_reg >= low_reg) && (mid_reg < high_reg))
    `IRL_ASSERT_NEXT(a_finish_loads_out, cmd.finish, out_valid_reg)

endmodule
